@@ design/bpsm_pkg.sv @@
`timescale 1ns / 1ps
package bpsm_pkg;

  localparam int SLOT_COUNT       = 32;
  localparam int DISK_BLOCK_COUNT = 8192;
  localparam int AGE_BITS         = 16;

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int BLK_W = $clog2(DISK_BLOCK_COUNT);
  localparam int NUM_W = 15;

  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  localparam logic [1:0] MODE_ALLOC  = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_DIRTY  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BOUND  = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  // Search token that walks the row of slot cells, one cell per cycle.
  typedef struct packed {
    logic                valid;
    logic                alloc;
    logic [BLK_W-1:0]    blk;
    logic                found;
    logic [IDX_W-1:0]    found_idx;
    logic                free_found;
    logic [IDX_W-1:0]    free_idx;
    logic [AGE_BITS-1:0] best_age;
    logic [IDX_W-1:0]    best_idx;
    logic                best_dirty;
    logic [BLK_W-1:0]    best_blk;
  } token_t;

  // Update broadcast to all cells once a request has been resolved.
  typedef struct packed {
    logic             fill;
    logic             set_dirty;
    logic [IDX_W-1:0] idx;
    logic [BLK_W-1:0] blk;
  } commit_t;

endpackage

@@ design/bpsm_cell.sv @@
`timescale 1ns / 1ps
module bpsm_cell
  import bpsm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] my_idx,
  input  token_t           tok_in,
  input  commit_t          commit,
  output token_t           tok_out
);

  logic                valid;
  logic                dirty;
  logic [BLK_W-1:0]    blk;
  logic [AGE_BITS-1:0] age;
  logic [AGE_BITS-1:0] age_next;
  logic                aging;
  logic                hit_me;
  token_t              tok_next;

  // The age a slot has once this allocate request has aged it.
  assign aging    = tok_in.valid && tok_in.alloc && valid;
  assign age_next = (aging && age != AGE_MAX) ? age + AGE_BITS'(1) : age;
  assign hit_me   = commit.idx == my_idx;

  always_comb begin
    tok_next = tok_in;
    if (!tok_in.found && valid && blk == tok_in.blk) begin
      tok_next.found     = 1'b1;
      tok_next.found_idx = my_idx;
    end
    if (!tok_in.free_found && !valid) begin
      tok_next.free_found = 1'b1;
      tok_next.free_idx   = my_idx;
    end
    // Strictly greater keeps the lowest index on ties.
    if (valid && age_next > tok_in.best_age) begin
      tok_next.best_age   = age_next;
      tok_next.best_idx   = my_idx;
      tok_next.best_dirty = dirty;
      tok_next.best_blk   = blk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= 1'b0;
      dirty         <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
      if (aging) begin
        age <= age_next;
      end
      if (commit.fill && hit_me) begin
        valid <= 1'b1;
        dirty <= 1'b0;
        blk   <= commit.blk;
        age   <= '0;
      end else if (commit.set_dirty && hit_me) begin
        dirty <= 1'b1;
      end
    end
  end

endmodule

@@ design/buffer_pool_slot_manager_top.sv @@
`timescale 1ns / 1ps
// An in-range request is registered into the search token, passes through every slot cell
// register in order and is resolved in the result registers that drive done.
// The block takes no new request while busy, that is until the token has left the last cell; an
// out-of-range block number is answered in the next cycle and does not raise busy.
// Reset (rst, synchronous, active high) frees every slot and cancels a request in flight.
// Each result is shown for exactly one cycle with done high; the receiver cannot stall.
module buffer_pool_slot_manager_top
  import bpsm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             mode,
  input  logic signed [NUM_W-1:0] block_num,
  output logic                   done,
  output logic [1:0]             status,
  output logic [IDX_W-1:0]       slot_index,
  output logic                   writeback_needed,
  output logic [BLK_W-1:0]       writeback_block
);

  // The slot table is a row of cells. An accepted request becomes a token that enters
  // cell 0 and moves one cell per cycle. Each cell ages its own slot as the token passes
  // (allocate only) and folds its slot into the token's running first-match, first-free
  // and oldest-slot search. When the token leaves the last cell the request is resolved
  // here, and the resulting slot write is broadcast to all cells in the result cycle.

  token_t     tok_chain [SLOT_COUNT+1];
  token_t     inject;
  token_t     last_tok;
  commit_t    commit;
  logic       accept;
  logic       out_of_bound;
  // Mode of the request in flight; only the mark-dirty case needs it at resolution.
  logic [1:0] mode_q;

  assign accept   = start && !busy;
  assign last_tok = tok_chain[SLOT_COUNT];
  assign tok_chain[0] = inject;

  // A set sign bit means a negative block number; otherwise compare the magnitude.
  assign out_of_bound = block_num[NUM_W-1] ||
                        ({1'b0, block_num[NUM_W-2:0]} >= NUM_W'(DISK_BLOCK_COUNT));

  genvar gi;
  generate
    for (gi = 0; gi < SLOT_COUNT; gi++) begin : g_cell
      bpsm_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .my_idx  (IDX_W'(gi)),
        .tok_in  (tok_chain[gi]),
        .commit  (commit),
        .tok_out (tok_chain[gi+1])
      );
    end
  endgenerate

  // Request intake: out-of-range requests are answered at once, the rest launch a token.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      inject.valid <= 1'b0;
    end else begin
      inject <= '0;
      if (accept && !out_of_bound) begin
        busy         <= 1'b1;
        inject.valid <= 1'b1;
        inject.alloc <= (mode == MODE_ALLOC);
        inject.blk   <= block_num[BLK_W-1:0];
      end else if (last_tok.valid) begin
        // The commit lands at the end of the result cycle, so a request accepted in that
        // cycle already sees the updated table.
        busy <= 1'b0;
      end
    end
  end

  // Resolution of the token leaving the last cell, and of out-of-range requests.
  always_ff @(posedge clk) begin
    if (rst) begin
      done             <= 1'b0;
      commit.fill      <= 1'b0;
      commit.set_dirty <= 1'b0;
    end else begin
      done             <= 1'b0;
      commit.fill      <= 1'b0;
      commit.set_dirty <= 1'b0;
      if (accept && out_of_bound) begin
        done             <= 1'b1;
        status           <= ST_BOUND;
        slot_index       <= '0;
        writeback_needed <= 1'b0;
        writeback_block  <= '0;
      end else if (last_tok.valid) begin
        done             <= 1'b1;
        commit.blk       <= last_tok.blk;
        writeback_needed <= 1'b0;
        writeback_block  <= '0;
        if (last_tok.alloc) begin
          status      <= ST_OK;
          commit.fill <= 1'b1;
          if (last_tok.free_found) begin
            slot_index <= last_tok.free_idx;
            commit.idx <= last_tok.free_idx;
          end else begin
            // Table full: evict the oldest slot and report its block if it is dirty.
            slot_index       <= last_tok.best_idx;
            commit.idx       <= last_tok.best_idx;
            writeback_needed <= last_tok.best_dirty;
            writeback_block  <= last_tok.best_dirty ? last_tok.best_blk : '0;
          end
        end else if (last_tok.found) begin
          status           <= ST_OK;
          slot_index       <= last_tok.found_idx;
          commit.idx       <= last_tok.found_idx;
          commit.set_dirty <= (mode_q == MODE_DIRTY);
        end else begin
          status     <= ST_ABSENT;
          slot_index <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= mode;
    end
  end

  // Results always arrive with the block ready for the next transfer.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while a request is still in flight");

  a_launch: assert property (@(posedge clk) disable iff (rst)
    (accept && !out_of_bound) |=> (busy && inject.valid))
    else $error("in-range request did not launch a search token");

  a_commit_with_result: assert property (@(posedge clk) disable iff (rst)
    (commit.fill || commit.set_dirty) |-> (done && status == ST_OK))
    else $error("slot update without a successful result");

  a_fail_index: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (slot_index == '0 && !writeback_needed))
    else $error("failed request reports a slot");

  a_single_token: assert property (@(posedge clk) disable iff (rst)
    inject.valid |-> !last_tok.valid)
    else $error("two search tokens in the cell row");

endmodule

@@ test/bpsm_reply_checker.sv @@
`timescale 1ns / 1ps
// Watches both channels of the slot manager, keeps its own copy of the slot table
// and compares every reply with the one it worked out when the request was taken.
module bpsm_reply_checker
  import bpsm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic [1:0]              mode,
  input  logic signed [NUM_W-1:0] block_num,
  input  logic                    done,
  input  logic [1:0]              status,
  input  logic [IDX_W-1:0]        slot_index,
  input  logic                    writeback_needed,
  input  logic [BLK_W-1:0]        writeback_block,
  output int                      fail_count,
  output int                      outstanding,
  output int                      replies_checked,
  output int                      writebacks_seen
);

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] slot;
    logic             wb;
    logic [BLK_W-1:0] wb_blk;
  } reply_t;

  logic                cached   [SLOT_COUNT];
  logic                modified [SLOT_COUNT];
  logic [BLK_W-1:0]    holds    [SLOT_COUNT];
  logic [AGE_BITS-1:0] age      [SLOT_COUNT];

  reply_t replies_due[$];
  int     mismatches = 0;
  int     checked = 0;
  int     writebacks = 0;

  // Applies one request to the slot table and returns the reply it should get.
  function automatic reply_t serve_request(input logic [1:0] op,
                                           input logic signed [NUM_W-1:0] num);
    reply_t r;
    int     pick;
    int     hit;
    r = '0;
    r.status = ST_OK;
    if (num < 0 || num >= DISK_BLOCK_COUNT) begin
      r.status = ST_BOUND;
    end else if (op == MODE_ALLOC) begin
      pick = -1;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (cached[i] && age[i] != AGE_MAX) age[i]++;
      end
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
        if (!cached[i]) pick = i;
      end
      if (pick < 0) begin
        // Table is full: the oldest slot goes, lowest index wins a tie.
        pick = 0;
        for (int i = 1; i < SLOT_COUNT; i++) begin
          if (age[i] > age[pick]) pick = i;
        end
        if (modified[pick]) begin
          r.wb     = 1'b1;
          r.wb_blk = holds[pick];
        end
      end
      cached[pick]   = 1'b1;
      modified[pick] = 1'b0;
      holds[pick]    = num[BLK_W-1:0];
      age[pick]      = '0;
      r.slot         = IDX_W'(pick);
    end else begin
      hit = -1;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
        if (cached[i] && holds[i] == num[BLK_W-1:0]) hit = i;
      end
      if (hit < 0) begin
        r.status = ST_ABSENT;
      end else begin
        if (op == MODE_DIRTY) modified[hit] = 1'b1;
        r.slot = IDX_W'(hit);
      end
    end
    return r;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        cached[i]   = 1'b0;
        modified[i] = 1'b0;
        holds[i]    = '0;
        age[i]      = '0;
      end
      replies_due.delete();
    end else begin
      if (start && !busy) replies_due.push_back(serve_request(mode, block_num));
      if (done) begin
        if (replies_due.size() == 0) begin
          $display("%0t: reply with no request outstanding, actual status %0d slot %0d",
                   $time, status, slot_index);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          check_field("status", 32'(want.status), 32'(status));
          check_field("slot_index", 32'(want.slot), 32'(slot_index));
          check_field("writeback_needed", 32'(want.wb), 32'(writeback_needed));
          check_field("writeback_block", 32'(want.wb_blk), 32'(writeback_block));
          checked++;
          if (want.wb) writebacks++;
        end
      end
    end
    fail_count      <= mismatches;
    outstanding     <= replies_due.size();
    replies_checked <= checked;
    writebacks_seen <= writebacks;
  end

endmodule

@@ test/buffer_pool_slot_manager_top_tb.sv @@
`timescale 1ns / 1ps
// Top of the slot manager bench. It makes the clock and reset, drives requests
// through the start/busy handshake and gives the verdict; all prediction and
// comparison lives in the checker instantiated beside the block.
module buffer_pool_slot_manager_top_tb;
  import bpsm_pkg::*;

  // Mode 3 is not defined by the block; it must behave like a lookup.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1780;
  localparam int POOL_SIZE    = 48;
  // Longest quiet stretch between transfers is one search plus the longest gap
  // between requests; the limit leaves a wide margin over that.
  localparam int IDLE_LIMIT   = 2000;
  // Tail after the last reply: longer than one full search, so a stray late reply is caught.
  localparam int DRAIN_CYCLES = SLOT_COUNT + 8;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic [1:0]              mode = MODE_ALLOC;
  logic signed [NUM_W-1:0] block_num = '0;
  logic                    busy;
  logic                    done;
  logic [1:0]              status;
  logic [IDX_W-1:0]        slot_index;
  logic                    writeback_needed;
  logic [BLK_W-1:0]        writeback_block;

  int fail_count;
  int outstanding;
  int replies_checked;
  int writebacks_seen;
  int requests_sent = 0;
  int stall_cycles = 0;

  always #5 clk = ~clk;

  buffer_pool_slot_manager_top DUT (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .mode             (mode),
    .block_num        (block_num),
    .done             (done),
    .status           (status),
    .slot_index       (slot_index),
    .writeback_needed (writeback_needed),
    .writeback_block  (writeback_block)
  );

  bpsm_reply_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .mode             (mode),
    .block_num        (block_num),
    .done             (done),
    .status           (status),
    .slot_index       (slot_index),
    .writeback_needed (writeback_needed),
    .writeback_block  (writeback_block),
    .fail_count       (fail_count),
    .outstanding      (outstanding),
    .replies_checked  (replies_checked),
    .writebacks_seen  (writebacks_seen)
  );

  // Presents one request after an idle gap and holds it until the block takes it.
  // Start is only lowered when a gap follows, so a back-to-back request keeps start
  // high across the transfer edge instead of dropping and raising it in one step.
  // Busy is read right after the edge, which is the value the block sampled there.
  task automatic send_request(input logic [1:0] op, input logic signed [NUM_W-1:0] num,
                              input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    mode      <= op;
    block_num <= num;
    @(posedge clk);
    while (busy) @(posedge clk);
    requests_sent++;
  endtask

  // The watchdog restarts on every request or reply transfer. A hung block or a
  // lost reply lets it run out, and the run ends as a failure.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d replies still outstanding",
               $time, IDLE_LIMIT, outstanding);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [BLK_W-1:0]        pool [POOL_SIZE];
    logic [1:0]              op;
    logic signed [NUM_W-1:0] num;
    int                      draw;
    int                      gap;
    bit                      burst;

    // A small working set of block numbers, spread over the whole disk, makes
    // lookups and dirty marks hit often; it is larger than the table, so the
    // table fills up and evictions of both clean and dirty slots follow.
    for (int i = 0; i < POOL_SIZE; i++) pool[i] = BLK_W'($urandom_range(0, DISK_BLOCK_COUNT - 1));
    burst = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part. On an empty table nothing is found; out-of-range numbers
    // at both ends and on both sides of zero are rejected in every mode.
    send_request(MODE_LOOKUP, NUM_W'(0), $urandom_range(0, 3));
    send_request(MODE_DIRTY, NUM_W'(DISK_BLOCK_COUNT - 1), $urandom_range(0, 3));
    send_request(MODE_ALLOC, NUM_W'(-1), $urandom_range(0, 3));
    send_request(MODE_LOOKUP, NUM_W'(-16384), $urandom_range(0, 3));
    send_request(MODE_DIRTY, NUM_W'(DISK_BLOCK_COUNT), $urandom_range(0, 3));
    send_request(MODE_UNUSED, NUM_W'(16383), $urandom_range(0, 3));
    // Fill the lowest free slots with the extreme block numbers and find them
    // again, the unused mode acting as a lookup.
    send_request(MODE_ALLOC, NUM_W'(0), $urandom_range(0, 3));
    send_request(MODE_ALLOC, NUM_W'(DISK_BLOCK_COUNT - 1), $urandom_range(0, 3));
    send_request(MODE_LOOKUP, NUM_W'(DISK_BLOCK_COUNT - 1), $urandom_range(0, 3));
    send_request(MODE_UNUSED, NUM_W'(0), $urandom_range(0, 3));
    send_request(MODE_DIRTY, NUM_W'(DISK_BLOCK_COUNT - 1), $urandom_range(0, 3));
    // Allocating a block that is already cached takes a further slot; a lookup
    // then reports the lower of the two.
    send_request(MODE_ALLOC, NUM_W'(0), $urandom_range(0, 3));
    send_request(MODE_LOOKUP, NUM_W'(0), $urandom_range(0, 3));
    send_request(MODE_DIRTY, NUM_W'(0), $urandom_range(0, 3));
    send_request(MODE_ALLOC, NUM_W'(13'h1555), $urandom_range(0, 3));
    send_request(MODE_ALLOC, NUM_W'(13'h0AAA), $urandom_range(0, 3));
    send_request(MODE_LOOKUP, NUM_W'(4096), $urandom_range(0, 3));
    // A rejected allocation must not age the table.
    send_request(MODE_ALLOC, NUM_W'(DISK_BLOCK_COUNT), $urandom_range(0, 3));
    send_request(MODE_DIRTY, NUM_W'(13'h0AAA), $urandom_range(0, 3));
    send_request(MODE_UNUSED, NUM_W'(4096), $urandom_range(0, 3));

    // Random part. Allocations dominate so the table stays full and evictions
    // keep coming; the rest hits or misses the working set. Every so often the
    // sender switches between back-to-back bursts and random gaps.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 19) == 0) begin
        pool[$urandom_range(0, POOL_SIZE - 1)] = BLK_W'($urandom_range(0, DISK_BLOCK_COUNT - 1));
      end

      draw = $urandom_range(0, 19);
      if (draw < 8) begin
        op = MODE_ALLOC;
      end else if (draw < 13) begin
        op = MODE_LOOKUP;
      end else if (draw < 18) begin
        op = MODE_DIRTY;
      end else begin
        op = MODE_UNUSED;
      end

      draw = $urandom_range(0, 99);
      if (draw < 70) begin
        num = NUM_W'(pool[$urandom_range(0, POOL_SIZE - 1)]);
      end else if (draw < 90) begin
        num = NUM_W'($urandom_range(0, DISK_BLOCK_COUNT - 1));
      end else if (draw < 95) begin
        // Negative numbers: the sign bit is set.
        num = NUM_W'($urandom_range(16384, 32767));
      end else begin
        num = NUM_W'($urandom_range(DISK_BLOCK_COUNT, 16383));
      end

      gap = burst ? 0 : $urandom_range(0, 3);
      send_request(op, num, gap);
    end
    start <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests over all modes, in and out of range;", requests_sent);
    $display("%0d replies compared, %0d of them evictions with a dirty write-back.",
             replies_checked, writebacks_seen);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
